@@ design/assert_macros.svh @@
// assertion macros used by variadic_int16_alu
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif

`ifndef SYNTH
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ design/vialu_pkg.sv @@
package vialu_pkg;

  localparam int OP_W = 5;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_ADD   = 5'd0;
  localparam op_t OP_SUB   = 5'd1;
  localparam op_t OP_MUL   = 5'd2;
  localparam op_t OP_DIV   = 5'd3;
  localparam op_t OP_MOD   = 5'd4;
  localparam op_t OP_SHIFT = 5'd5;
  localparam op_t OP_AND   = 5'd6;
  localparam op_t OP_OR    = 5'd7;
  localparam op_t OP_XOR   = 5'd8;
  localparam op_t OP_NOR   = 5'd9;
  localparam op_t OP_LAND  = 5'd10;
  localparam op_t OP_LOR   = 5'd11;
  localparam op_t OP_GT    = 5'd12;
  localparam op_t OP_GE    = 5'd13;
  localparam op_t OP_EQ    = 5'd14;
  localparam op_t OP_LE    = 5'd15;
  localparam op_t OP_LT    = 5'd16;

  typedef enum logic [1:0] {
    ERR_OK,
    ERR_COUNT,
    ERR_DIV_ZERO,
    ERR_UNKNOWN_OP
  } err_t;

  typedef enum logic [3:0] {
    K_ADD,
    K_SUB,
    K_MUL,
    K_AND,
    K_OR,
    K_XOR,
    K_NOR,
    K_DIV,
    K_MOD,
    K_SHIFT
  } eng_kind_t;

  typedef struct packed {
    logic      start;
    eng_kind_t kind;
  } eng_req_t;

endpackage

@@ design/vialu_in_if.sv @@
interface vialu_in_if #(parameter int DATA_WIDTH = 16);
  import vialu_pkg::*;

  logic                         valid;
  logic                         ready;
  op_t                          op;
  logic signed [DATA_WIDTH-1:0] operand_value;
  logic                         last_operand;

  modport source (output valid, op, operand_value, last_operand, input ready);
  modport sink (input valid, op, operand_value, last_operand, output ready);
endinterface

@@ design/vialu_out_if.sv @@
interface vialu_out_if #(parameter int DATA_WIDTH = 16);
  import vialu_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_value;
  err_t                         error_code;

  modport source (output valid, result_value, error_code, input ready);
  modport sink (input valid, result_value, error_code, output ready);
endinterface

@@ design/vialu_serial.sv @@
module vialu_serial #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  vialu_pkg::eng_req_t      req,
  input  logic [DATA_WIDTH-1:0]    a,
  input  logic [DATA_WIDTH-1:0]    b,
  output logic                     done,
  output logic [DATA_WIDTH-1:0]    value
);
  import vialu_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam logic [W-1:0]  W_U      = W'(W);
  localparam logic [W:0]    W_M1_EXT = (W + 1)'(W - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(W);
  localparam logic [CW-1:0] CNT_RMAX = CW'(W - 1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  typedef enum logic [1:0] {E_IDLE, E_RUN, E_FIX} estate_t;

  estate_t       state;
  eng_kind_t     kind;
  logic [W-1:0]  ra;
  logic [W-1:0]  rb;
  logic [W-1:0]  p;
  logic          carry;
  logic [CW-1:0] cnt;
  logic          shl;
  logic          neg_q;
  logic          neg_r;

  logic          ai;
  logic          bi;
  logic          sum;
  logic          cy;
  logic          bit_out;
  logic [W:0]    rem_shift;
  logic [W:0]    trial;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic          b_pos;
  logic [W:0]    negb;
  logic [CW-1:0] n_sh;

  // one bit per cycle for add, sub and bitwise ops
  always_comb begin
    ai  = ra[0];
    bi  = rb[0] ^ (kind == K_SUB);
    sum = ai ^ bi ^ carry;
    cy  = (ai & bi) | (ai & carry) | (bi & carry);
    unique case (kind)
      K_AND:   bit_out = ai & rb[0];
      K_OR:    bit_out = ai | rb[0];
      K_XOR:   bit_out = ai ^ rb[0];
      K_NOR:   bit_out = ~(ai | rb[0]);
      default: bit_out = sum;
    endcase
  end

  // restoring divide step, remainder lives in p
  assign rem_shift = {p, ra[W-1]};
  assign trial     = rem_shift - {1'b0, rb};

  assign mag_a = a[W-1] ? (~a + 1'b1) : a;
  assign mag_b = b[W-1] ? (~b + 1'b1) : b;

  // shift amount, clamped so the serial shifter never runs past the word
  always_comb begin
    b_pos = !b[W-1] && (|b);
    negb  = ~{b[W-1], b} + 1'b1;
    if (b_pos) begin
      n_sh = (b >= W_U) ? CNT_FULL : b[CW-1:0];
    end else begin
      n_sh = (negb >= W_M1_EXT) ? CNT_RMAX : negb[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        E_IDLE: begin
          done <= req.start && (req.kind == K_SHIFT) && (n_sh == '0);
          if (req.start) begin
            kind  <= req.kind;
            carry <= (req.kind == K_SUB);
            neg_q <= a[W-1] ^ b[W-1];
            neg_r <= a[W-1];
            shl   <= b_pos;
            unique case (req.kind)
              K_DIV, K_MOD: begin
                cnt   <= CNT_FULL;
                ra    <= mag_a;
                rb    <= mag_b;
                p     <= '0;
                state <= E_RUN;
              end
              K_SHIFT: begin
                cnt   <= n_sh;
                ra    <= a;
                rb    <= b;
                p     <= a;
                state <= (n_sh == '0) ? E_IDLE : E_RUN;
              end
              default: begin
                cnt   <= CNT_FULL;
                ra    <= a;
                rb    <= b;
                p     <= '0;
                state <= E_RUN;
              end
            endcase
          end
        end
        E_RUN: begin
          cnt  <= cnt - 1'b1;
          done <= (cnt == CNT_ONE) && (kind != K_DIV) && (kind != K_MOD);
          unique case (kind)
            K_MUL: begin
              if (rb[0]) begin
                p <= p + ra;
              end
              ra <= {ra[W-2:0], 1'b0};
              rb <= {1'b0, rb[W-1:1]};
            end
            K_DIV, K_MOD: begin
              if (!trial[W]) begin
                p  <= trial[W-1:0];
                ra <= {ra[W-2:0], 1'b1};
              end else begin
                p  <= rem_shift[W-1:0];
                ra <= {ra[W-2:0], 1'b0};
              end
            end
            K_SHIFT: begin
              p <= shl ? {p[W-2:0], 1'b0} : {p[W-1], p[W-1:1]};
            end
            default: begin
              p     <= {bit_out, p[W-1:1]};
              ra    <= {1'b0, ra[W-1:1]};
              rb    <= {1'b0, rb[W-1:1]};
              carry <= cy;
            end
          endcase
          if (cnt == CNT_ONE) begin
            if (kind == K_DIV || kind == K_MOD) begin
              state <= E_FIX;
            end else begin
              state <= E_IDLE;
            end
          end
        end
        E_FIX: begin
          if (kind == K_DIV) begin
            p <= neg_q ? (~ra + 1'b1) : ra;
          end else begin
            p <= neg_r ? (~p + 1'b1) : p;
          end
          state <= E_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= E_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  assign value = p;

endmodule

@@ design/variadic_int16_alu.sv @@
// Folding expression ALU. Operands of one expression arrive one beat at a time on the operand
// channel; the op field of the first beat picks the operator, and the beat marked last_operand
// closes the run and yields one result beat (value plus error code) on the result channel.
// Add, sub, mul, the bitwise ops, land and lor fold over any number of operands; div, mod,
// shift and the compares need exactly two. Arithmetic runs through a bit-serial unit one bit
// per cycle, so its run time grows with DATA_WIDTH: the first beat of a run only loads the
// accumulator; each later add/sub/mul/and/or/xor/nor beat runs the serial unit over the word;
// a closing div or mod runs it over the word and then fixes the signs, a closing shift runs it
// for the clamped shift amount, and compares, land and lor skip the unit. A closing beat then
// loads the output register, which holds a result while the next run's beats are taken.
`include "assert_macros.svh"

module variadic_int16_alu #(
  parameter int DATA_WIDTH = 16
) (
  input logic         clk,
  input logic         rst,
  vialu_in_if.sink    operand,
  vialu_out_if.source result
);
  import vialu_pkg::*;

  localparam int W = DATA_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_FOLD, S_FIN, S_EMIT} state_t;

  state_t        state;
  logic [W-1:0]  acc;
  logic [1:0]    count;
  op_t           held;
  logic          run_active;
  logic          pend_last;
  logic [W-1:0]  pend_res;
  err_t          pend_err;
  logic          out_valid;
  logic [W-1:0]  out_res;
  err_t          out_err;

  logic          accept;
  logic          last;
  op_t           hop;
  logic [W-1:0]  x;
  logic          x_nz;
  logic          acc_nz;
  logic [1:0]    cnt_new;
  logic          is_unknown;
  logic          is_two;
  logic          is_fold_eng;
  logic          is_logic;
  logic [W-1:0]  acc_first;
  err_t          first_err;
  logic [W-1:0]  logic_new;
  err_t          two_err;
  logic          two_eng;
  logic          cmp_true;
  eng_kind_t     kind;
  eng_req_t      eng_req;
  logic          eng_done;
  logic [W-1:0]  eng_result;

  assign accept = operand.valid && operand.ready;
  assign last   = operand.last_operand;
  assign x      = operand.operand_value;

  always_comb begin
    hop         = run_active ? held : operand.op;
    x_nz        = |x;
    acc_nz      = |acc;
    cnt_new     = !run_active ? 2'd1 : ((count == 2'd3) ? 2'd3 : count + 2'd1);
    is_unknown  = hop > OP_LT;
    is_two      = hop == OP_DIV || hop == OP_MOD || hop == OP_SHIFT || hop >= OP_GT;
    is_logic    = hop == OP_LAND || hop == OP_LOR;
    is_fold_eng = !is_two && !is_logic;
    acc_first   = is_logic ? W'(x_nz) : x;

    if (is_unknown) begin
      first_err = ERR_UNKNOWN_OP;
    end else if (is_two) begin
      first_err = ERR_COUNT;
    end else begin
      first_err = ERR_OK;
    end

    logic_new = (hop == OP_LAND) ? W'(acc_nz && x_nz) : W'(acc_nz || x_nz);

    priority if (is_unknown) begin
      two_err = ERR_UNKNOWN_OP;
    end else if (cnt_new != 2'd2) begin
      two_err = ERR_COUNT;
    end else if ((hop == OP_DIV || hop == OP_MOD) && !x_nz) begin
      two_err = ERR_DIV_ZERO;
    end else begin
      two_err = ERR_OK;
    end
    two_eng = (two_err == ERR_OK) && (hop == OP_DIV || hop == OP_MOD || hop == OP_SHIFT);

    unique case (hop)
      OP_GT:   cmp_true = $signed(acc) >  $signed(x);
      OP_GE:   cmp_true = $signed(acc) >= $signed(x);
      OP_EQ:   cmp_true = acc == x;
      OP_LE:   cmp_true = $signed(acc) <= $signed(x);
      OP_LT:   cmp_true = $signed(acc) <  $signed(x);
      default: cmp_true = 1'b0;
    endcase

    unique case (hop)
      OP_SUB:   kind = K_SUB;
      OP_MUL:   kind = K_MUL;
      OP_AND:   kind = K_AND;
      OP_OR:    kind = K_OR;
      OP_XOR:   kind = K_XOR;
      OP_NOR:   kind = K_NOR;
      OP_DIV:   kind = K_DIV;
      OP_MOD:   kind = K_MOD;
      OP_SHIFT: kind = K_SHIFT;
      default:  kind = K_ADD;
    endcase

    eng_req.start = accept && run_active && (is_fold_eng || (last && two_eng));
    eng_req.kind  = kind;
  end

  vialu_serial #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_serial (
    .clk  (clk),
    .rst  (rst),
    .req  (eng_req),
    .a    (acc),
    .b    (x),
    .done (eng_done),
    .value(eng_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      acc        <= '0;
      count      <= '0;
      held       <= OP_ADD;
      run_active <= 1'b0;
      pend_last  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && result.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!run_active) begin
              held       <= operand.op;
              count      <= 2'd1;
              run_active <= 1'b1;
              acc        <= acc_first;
              if (last) begin
                pend_err <= first_err;
                pend_res <= (first_err == ERR_OK) ? acc_first : '0;
                state    <= S_EMIT;
              end
            end else begin
              count     <= cnt_new;
              pend_last <= last;
              if (is_fold_eng) begin
                state <= S_FOLD;
              end else if (is_logic) begin
                acc <= logic_new;
                if (last) begin
                  pend_res <= logic_new;
                  pend_err <= ERR_OK;
                  state    <= S_EMIT;
                end
              end else if (last) begin
                if (two_eng) begin
                  state <= S_FIN;
                end else begin
                  pend_err <= two_err;
                  pend_res <= (two_err == ERR_OK) ? W'(cmp_true) : '0;
                  state    <= S_EMIT;
                end
              end
            end
          end
        end
        S_FOLD: begin
          if (eng_done) begin
            acc <= eng_result;
            if (pend_last) begin
              pend_res <= eng_result;
              pend_err <= ERR_OK;
              state    <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          if (eng_done) begin
            pend_res <= eng_result;
            pend_err <= ERR_OK;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_res    <= pend_res;
            out_err    <= pend_err;
            acc        <= '0;
            count      <= '0;
            held       <= OP_ADD;
            run_active <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign operand.ready       = (state == S_IDLE);
  assign result.valid        = out_valid;
  assign result.result_value = out_res;
  assign result.error_code   = out_err;

  `ASSERT_IMPLIES(a_err_zero, clk, rst, result.valid && (result.error_code != ERR_OK), result.result_value == '0)
  `ASSERT_NEXT(a_start_stalls, clk, rst, eng_req.start, !operand.ready)
  `ASSERT_NEXT(a_emit_closes, clk, rst, (state == S_EMIT) && (!out_valid || result.ready), result.valid && !run_active && (count == 2'd0))
  `ASSERT_IMPLIES(a_done_busy, clk, rst, eng_done, (state == S_FOLD) || (state == S_FIN))

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import vialu_pkg::*;

  localparam int W = 16;
  localparam int RANDOM_BEATS = 400;
  localparam int IDLE_LIMIT = 2000;
  localparam int DIR_ROWS = 29;
  localparam op_t OP_CODE_MAX = 5'd31;

  typedef logic signed [W-1:0] word_t;

  localparam word_t WORD_MIN = 16'h8000;
  localparam word_t WORD_MAX = 16'h7fff;

  typedef struct packed {
    word_t value;
    err_t  code;
  } alu_result_t;

  typedef struct {
    op_t         op;
    word_t       value;
    logic        closes;
    logic        pinned;
    alu_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vialu_in_if #(.DATA_WIDTH(W)) operand_ch ();
  vialu_out_if #(.DATA_WIDTH(W)) result_ch ();

  variadic_int16_alu #(.DATA_WIDTH(W)) DUT (
    .clk(clk),
    .rst(rst),
    .operand(operand_ch),
    .result(result_ch)
  );

  always #10 clk = ~clk;

  // expression state as the block should hold it
  word_t acc_q = '0;
  logic [1:0] count_q = '0;
  op_t held_op_q = OP_ADD;
  logic open_q = 1'b0;

  alu_result_t pending_results[$];
  logic pin_now = 1'b0;
  alu_result_t pin_val = '0;

  int beats_taken = 0;
  int results_checked = 0;
  int error_results = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{OP_ADD,      WORD_MAX,     1'b0, 1'b0, '{16'sd0, ERR_OK}},
    '{OP_CODE_MAX, 16'sd1,       1'b1, 1'b1, '{WORD_MIN, ERR_OK}},
    '{OP_SUB,      WORD_MIN,     1'b1, 1'b1, '{WORD_MIN, ERR_OK}},
    '{OP_MUL,      16'sd256,     1'b0, 1'b0, '{16'sd0, ERR_OK}},
    '{OP_MUL,      16'sd256,     1'b1, 1'b1, '{16'sd0, ERR_OK}},
    '{OP_DIV,      WORD_MIN,     1'b0, 1'b0, '{16'sd0, ERR_OK}},
    '{OP_DIV,      -16'sd1,      1'b1, 1'b1, '{WORD_MIN, ERR_OK}},
    '{OP_MOD,      WORD_MIN,     1'b0, 1'b0, '{16'sd0, ERR_OK}},
    '{OP_MOD,      -16'sd1,      1'b1, 1'b1, '{16'sd0, ERR_OK}},
    '{OP_DIV,      16'sd5,       1'b0, 1'b0, '{16'sd0, ERR_OK}},
    '{OP_DIV,      16'sd0,       1'b1, 1'b1, '{16'sd0, ERR_DIV_ZERO}},
    '{OP_SHIFT,    16'sd1,       1'b0, 1'b0, '{16'sd0, ERR_OK}},
    '{OP_SHIFT,    16'sd16,      1'b1, 1'b1, '{16'sd0, ERR_OK}},
    '{OP_SHIFT,    WORD_MIN,     1'b0, 1'b0, '{16'sd0, ERR_OK}},
    '{OP_SHIFT,    -16'sd15,     1'b1, 1'b1, '{-16'sd1, ERR_OK}},
    '{OP_AND,      -16'sd1,      1'b1, 1'b1, '{-16'sd1, ERR_OK}},
    '{OP_OR,       WORD_MIN,     1'b1, 1'b1, '{WORD_MIN, ERR_OK}},
    '{OP_XOR,      16'sh5555,    1'b1, 1'b1, '{16'sh5555, ERR_OK}},
    '{OP_NOR,      16'sd0,       1'b1, 1'b1, '{16'sd0, ERR_OK}},
    '{OP_LAND,     -16'sd5,      1'b1, 1'b1, '{16'sd1, ERR_OK}},
    '{OP_LOR,      16'sd0,       1'b1, 1'b1, '{16'sd0, ERR_OK}},
    '{OP_GT,       WORD_MAX,     1'b0, 1'b0, '{16'sd0, ERR_OK}},
    '{OP_GT,       WORD_MIN,     1'b1, 1'b0, '{16'sd0, ERR_OK}},
    '{OP_GE,       16'sd5,       1'b1, 1'b1, '{16'sd0, ERR_COUNT}},
    '{OP_EQ,       16'sd7,       1'b1, 1'b1, '{16'sd0, ERR_COUNT}},
    '{OP_LE,       -16'sd3,      1'b0, 1'b0, '{16'sd0, ERR_OK}},
    '{OP_LT,       16'sd7,       1'b1, 1'b0, '{16'sd0, ERR_OK}},
    '{OP_LT,       16'sd2,       1'b1, 1'b1, '{16'sd0, ERR_COUNT}},
    '{OP_CODE_MAX, 16'sd4,       1'b1, 1'b1, '{16'sd0, ERR_UNKNOWN_OP}}
  };

  function automatic bit is_pair_op(op_t o);
    return (o inside {OP_DIV, OP_MOD, OP_SHIFT}) || o >= OP_GT;
  endfunction

  function automatic word_t shift_word(word_t a, word_t b);
    int amt;
    amt = b;
    if (amt > 0) begin
      return (amt >= W) ? word_t'(0) : word_t'(a << amt);
    end
    amt = -amt;
    if (amt >= W - 1) begin
      return {W{a[W-1]}};
    end
    return a >>> amt;
  endfunction

  function automatic word_t fold_word(op_t o, word_t acc, word_t x);
    case (o)
      OP_ADD:  return acc + x;
      OP_SUB:  return acc - x;
      OP_MUL:  return acc * x;
      OP_AND:  return acc & x;
      OP_OR:   return acc | x;
      OP_XOR:  return acc ^ x;
      OP_NOR:  return ~(acc | x);
      OP_LAND: return word_t'(acc != 0 && x != 0);
      OP_LOR:  return word_t'(acc != 0 || x != 0);
      default: return acc;
    endcase
  endfunction

  function automatic alu_result_t close_expression(word_t x);
    alu_result_t r;
    int a;
    int b;
    r.value = '0;
    r.code = ERR_OK;
    a = acc_q;
    b = x;
    if (held_op_q > OP_LT) begin
      r.code = ERR_UNKNOWN_OP;
    end else if (!is_pair_op(held_op_q)) begin
      r.value = acc_q;
    end else if (count_q != 2'd2) begin
      r.code = ERR_COUNT;
    end else begin
      case (held_op_q)
        OP_DIV, OP_MOD: begin
          if (b == 0) r.code = ERR_DIV_ZERO;
          else r.value = (held_op_q == OP_DIV) ? word_t'(a / b) : word_t'(a % b);
        end
        OP_SHIFT: r.value = shift_word(acc_q, x);
        OP_GT:    r.value = word_t'(a > b);
        OP_GE:    r.value = word_t'(a >= b);
        OP_EQ:    r.value = word_t'(a == b);
        OP_LE:    r.value = word_t'(a <= b);
        default:  r.value = word_t'(a < b);
      endcase
    end
    return r;
  endfunction

  function automatic void fold_operand(op_t o, word_t x, logic closes, output bit done,
                                       output alu_result_t r);
    done = 1'b0;
    r = '0;
    if (!open_q) begin
      held_op_q = o;
      count_q = 2'd1;
      open_q = 1'b1;
      acc_q = (o == OP_LAND || o == OP_LOR) ? word_t'(x != 0) : x;
    end else begin
      if (count_q < 2'd3) count_q++;
      if (!is_pair_op(held_op_q)) acc_q = fold_word(held_op_q, acc_q, x);
    end
    if (closes) begin
      r = close_expression(x);
      done = 1'b1;
      acc_q = '0;
      count_q = '0;
      held_op_q = OP_ADD;
      open_q = 1'b0;
    end
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(0, 7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
      4, 5: return word_t'(int'($urandom_range(0, 40)) - 20);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic op_t pick_op();
    if ($urandom_range(0, 11) == 0) return op_t'($urandom_range(OP_LT + 1, OP_CODE_MAX));
    return op_t'($urandom_range(OP_ADD, OP_LT));
  endfunction

  function automatic int pick_burst();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48) : $urandom_range(0, 5);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic drive_beat(op_t o, word_t x, logic closes, logic pin, alu_result_t pv);
    operand_ch.valid <= 1'b1;
    operand_ch.op <= o;
    operand_ch.operand_value <= x;
    operand_ch.last_operand <= closes;
    pin_now = pin;
    pin_val = pv;
    do @(posedge clk); while (!operand_ch.ready);
    @(negedge clk);
    if (burst_left == 0) begin
      operand_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = pick_burst();
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    operand_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(30, 200);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= ($urandom_range(0, 3) != 0);
      default: result_ch.ready <= (stall_tick % 7 == 0);
    endcase
  end

  always @(posedge clk) begin : monitor
    bit accepted;
    bit done;
    alu_result_t r;
    alu_result_t want;
    if (!rst) begin
      accepted = 1'b0;
      if (operand_ch.valid && operand_ch.ready) begin
        accepted = 1'b1;
        beats_taken++;
        fold_operand(operand_ch.op, operand_ch.operand_value, operand_ch.last_operand, done, r);
        if (done) pending_results.push_back(pin_now ? pin_val : r);
      end
      if (result_ch.valid && result_ch.ready) begin
        accepted = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing pending: result_value %0d error_code %0d",
                 result_ch.result_value, result_ch.error_code);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (want.code != ERR_OK) error_results++;
          if (result_ch.result_value !== want.value) begin
            $error("result_value: expected %0d, actual %0d", want.value,
                   result_ch.result_value);
            mismatches++;
          end
          if (result_ch.error_code !== want.code) begin
            $error("error_code: expected %0d, actual %0d", want.code, result_ch.error_code);
            mismatches++;
          end
        end
      end
      if (accepted) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int run_len;
    int random_beats;
    op_t run_op;
    word_t x;
    operand_ch.valid = 1'b0;
    operand_ch.op = OP_ADD;
    operand_ch.operand_value = '0;
    operand_ch.last_operand = 1'b0;
    result_ch.ready = 1'b0;
    random_beats = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    burst_left = pick_burst();

    foreach (dir_rows[i]) begin
      drive_beat(dir_rows[i].op, dir_rows[i].value, dir_rows[i].closes, dir_rows[i].pinned,
                 dir_rows[i].want);
    end
    drain();

    while (random_beats < RANDOM_BEATS) begin
      run_op = pick_op();
      if (is_pair_op(run_op)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: run_len = 2;
          7: run_len = 1;
          default: run_len = $urandom_range(3, 7);
        endcase
      end else begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 4);
      end
      for (int i = 0; i < run_len; i++) begin
        x = pick_value();
        if (i == 1 && run_op == OP_SHIFT && $urandom_range(0, 3) != 0)
          x = word_t'(int'($urandom_range(0, 44)) - 22);
        if (i == 1 && (run_op == OP_DIV || run_op == OP_MOD) && $urandom_range(0, 7) == 0)
          x = '0;
        drive_beat((i == 0) ? run_op : op_t'($urandom), x, i == run_len - 1, 1'b0, '0);
        random_beats++;
      end
      if ($urandom_range(0, 24) == 0) drain();
    end
    drain();
    repeat (2 * W + 8) @(negedge clk);

    $display("covered %0d operand beats, %0d results checked, %0d of them with error codes",
             beats_taken, results_checked, error_results);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
